/* rtl/crpi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpi_pkg: shared types, widths and helpers of the Catmull-Rom interpolator
// Coordinate format, segment coefficient records, slot records and the
// constant functions that size the rounding divider.
// ----------------------------------------------------------------------------
package crpi_pkg;

  // coordinate format: signed, 4 fraction bits
  localparam int COORD_W    = 20;
  localparam int SUBDIV_DEF = 4;
  // coefficient widths: a = p2 - p0, b and c are four-term sums
  localparam int A_W        = 21;
  localparam int BC_W       = 24;
  // accumulator width of the sample numerator
  localparam int ACC_W      = 32;
  // register stages from slot issue to the result register
  localparam int PIPE_DEPTH = 5;

  typedef logic signed [COORD_W-1:0] coord_t;

  // one coordinate of one segment in polynomial form
  typedef struct packed {
    logic signed [COORD_W-1:0] p1;
    logic signed [A_W-1:0]     a;
    logic signed [BC_W-1:0]    b;
    logic signed [BC_W-1:0]    c;
  } coef_t;

  // one pending segment (or the closing point when single is set)
  typedef struct packed {
    logic  vld;
    logic  single;
    coef_t cx;
    coef_t cy;
  } slot_t;

  // sequencer status seen by the top level
  typedef struct packed {
    logic       busy;
    logic [1:0] seen;
  } seq_status_t;

  // uniform Catmull-Rom coefficients of segment p1 -> p2
  function automatic coef_t seg_coef(input coord_t p0, input coord_t p1,
                                     input coord_t p2, input coord_t p3);
    logic signed [BC_W-1:0] e0;
    logic signed [BC_W-1:0] e1;
    logic signed [BC_W-1:0] e2;
    logic signed [BC_W-1:0] e3;
    coef_t r;
    e0   = BC_W'(p0);
    e1   = BC_W'(p1);
    e2   = BC_W'(p2);
    e3   = BC_W'(p3);
    r.p1 = p1;
    r.a  = A_W'(e2 - e0);
    r.b  = BC_W'(2 * e0 - 5 * e1 + 4 * e2 - e3);
    r.c  = BC_W'(3 * e1 - e0 - 3 * e2 + e3);
    return r;
  endfunction

  // a point passed through: constant polynomial
  function automatic coef_t point_coef(input coord_t p);
    coef_t r;
    r.p1 = p;
    r.a  = '0;
    r.b  = '0;
    r.c  = '0;
    return r;
  endfunction

  // sample weights j*S^2, j^2*S, j^3 (at most 48 for S up to 4)
  function automatic logic [7:0] w_lin(input int j, input int s);
    return 8'(j * s * s);
  endfunction

  function automatic logic [7:0] w_quad(input int j, input int s);
    return 8'(j * j * s);
  endfunction

  function automatic logic [7:0] w_cube(input int j);
    return 8'(j * j * j);
  endfunction

  // trailing zero count of a positive constant
  function automatic int trail_zeros(input int v);
    int n;
    n = 0;
    for (int i = 0; i < 31; i++) begin
      if ((((v >> i) & 1) == 0) && (n == i)) begin
        n = i + 1;
      end
    end
    return n;
  endfunction

endpackage

/* rtl/crpi_point_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpi_point_if: polyline point channel
// Valid/ready channel carrying one polyline point and its final flag.
// ----------------------------------------------------------------------------
interface crpi_point_if;
  logic                  valid;
  logic                  ready;
  crpi_pkg::coord_t      point_x;
  crpi_pkg::coord_t      point_y;
  logic                  final_point;

  modport source (output valid, output point_x, output point_y,
                  output final_point, input ready);
  modport sink (input valid, input point_x, input point_y,
                input final_point, output ready);
endinterface

/* rtl/crpi_sample_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpi_sample_if: curve sample channel
// Valid/ready channel carrying one interpolated sample and the curve end flag.
// ----------------------------------------------------------------------------
interface crpi_sample_if;
  logic                  valid;
  logic                  ready;
  crpi_pkg::coord_t      sample_x;
  crpi_pkg::coord_t      sample_y;
  logic                  end_of_curve;

  modport source (output valid, output sample_x, output sample_y,
                  output end_of_curve, input ready);
  modport sink (input valid, input sample_x, input sample_y,
                input end_of_curve, output ready);
endinterface

/* rtl/crpi_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpi_seq: point window and segment sequencer
// Keeps the last three points, turns each accepted point into up to three
// pending slots (segments or the closing point) and issues one sample per
// advancing cycle.
// ----------------------------------------------------------------------------
module crpi_seq #(
  parameter int SUBDIV = crpi_pkg::SUBDIV_DEF,
  localparam int JW    = (SUBDIV > 1) ? $clog2(SUBDIV) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  crpi_point_if.sink             in_ch,
  input  logic                   adv_i,
  output logic                   issue_o,
  output logic                   issue_end_o,
  output logic [JW-1:0]          issue_j_o,
  output crpi_pkg::coef_t        issue_cx_o,
  output crpi_pkg::coef_t        issue_cy_o,
  output crpi_pkg::seq_status_t  status_o
);

  localparam logic [JW-1:0] J_LAST = JW'(SUBDIV - 1);

  crpi_pkg::coord_t win_x_r [3];
  crpi_pkg::coord_t win_y_r [3];
  logic [1:0]       seen_r;
  crpi_pkg::slot_t  slot_r  [3];
  crpi_pkg::slot_t  slot_nxt [3];
  logic [JW-1:0]    j_r;
  logic [JW-1:0]    j_nxt;

  logic accept;
  logic issue;
  logic slot_done;
  logic va, vb, vf;
  crpi_pkg::coef_t ax, ay, bx, by, fx, fy;

  // handshake and slot progress
  assign accept    = in_ch.valid && in_ch.ready;
  assign issue     = slot_r[0].vld && adv_i;
  assign slot_done = issue && (slot_r[0].single || (j_r == J_LAST));
  assign in_ch.ready = !slot_r[0].vld || (slot_done && !slot_r[1].vld);

  // segment coefficients for the arriving point
  always_comb begin
    va = (seen_r >= 2'd2);
    vb = in_ch.final_point && (seen_r >= 2'd1);
    vf = in_ch.final_point;
    // segment ending at the previous point; first point of three doubles as p0
    ax = crpi_pkg::seg_coef((seen_r == 2'd3) ? win_x_r[2] : win_x_r[1],
                            win_x_r[1], win_x_r[0], in_ch.point_x);
    ay = crpi_pkg::seg_coef((seen_r == 2'd3) ? win_y_r[2] : win_y_r[1],
                            win_y_r[1], win_y_r[0], in_ch.point_y);
    // closing segment: final point stands in for p3
    bx = crpi_pkg::seg_coef((seen_r >= 2'd2) ? win_x_r[1] : win_x_r[0],
                            win_x_r[0], in_ch.point_x, in_ch.point_x);
    by = crpi_pkg::seg_coef((seen_r >= 2'd2) ? win_y_r[1] : win_y_r[0],
                            win_y_r[0], in_ch.point_y, in_ch.point_y);
    fx = crpi_pkg::point_coef(in_ch.point_x);
    fy = crpi_pkg::point_coef(in_ch.point_y);
  end

  // slot list: load compacted on a transfer, else shift on slot completion
  always_comb begin
    slot_nxt[0] = slot_r[0];
    slot_nxt[1] = slot_r[1];
    slot_nxt[2] = slot_r[2];
    if (accept) begin
      slot_nxt[0].vld    = va || vf;
      slot_nxt[0].single = !va && !vb;
      slot_nxt[0].cx     = va ? ax : (vb ? bx : fx);
      slot_nxt[0].cy     = va ? ay : (vb ? by : fy);
      slot_nxt[1].vld    = vb;
      slot_nxt[1].single = !va;
      slot_nxt[1].cx     = va ? bx : fx;
      slot_nxt[1].cy     = va ? by : fy;
      slot_nxt[2].vld    = va && vb;
      slot_nxt[2].single = 1'b1;
      slot_nxt[2].cx     = fx;
      slot_nxt[2].cy     = fy;
    end else if (slot_done) begin
      slot_nxt[0]     = slot_r[1];
      slot_nxt[1]     = slot_r[2];
      slot_nxt[2].vld = 1'b0;
    end
  end

  // sample index within the current slot
  always_comb begin
    j_nxt = j_r;
    if (slot_done) begin
      j_nxt = '0;
    end else if (issue) begin
      j_nxt = j_r + JW'(1);
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 2'd0;
      j_r    <= '0;
      for (int i = 0; i < 3; i++) begin
        slot_r[i]  <= '0;
        win_x_r[i] <= '0;
        win_y_r[i] <= '0;
      end
    end else begin
      j_r <= j_nxt;
      for (int i = 0; i < 3; i++) begin
        slot_r[i] <= slot_nxt[i];
      end
      if (accept) begin
        if (in_ch.final_point) begin
          // polyline closed: start over
          seen_r <= 2'd0;
          for (int i = 0; i < 3; i++) begin
            win_x_r[i] <= '0;
            win_y_r[i] <= '0;
          end
        end else begin
          seen_r     <= (seen_r == 2'd3) ? seen_r : seen_r + 2'd1;
          win_x_r[2] <= win_x_r[1];
          win_y_r[2] <= win_y_r[1];
          win_x_r[1] <= win_x_r[0];
          win_y_r[1] <= win_y_r[0];
          win_x_r[0] <= in_ch.point_x;
          win_y_r[0] <= in_ch.point_y;
        end
      end
    end
  end

  assign issue_o       = issue;
  assign issue_end_o   = slot_r[0].single;
  assign issue_j_o     = j_r;
  assign issue_cx_o    = slot_r[0].cx;
  assign issue_cy_o    = slot_r[0].cy;
  assign status_o.busy = slot_r[0].vld;
  assign status_o.seen = seen_r;

endmodule

/* rtl/crpi_eval.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpi_eval: sample evaluation pipeline for one coordinate
// Weighted terms, numerator sum, saturation and offset, reciprocal multiply
// for the exact rounding divide, result register. Five stages, all enabled
// by the common advance.
// ----------------------------------------------------------------------------
module crpi_eval #(
  parameter int SUBDIV = crpi_pkg::SUBDIV_DEF,
  localparam int JW    = (SUBDIV > 1) ? $clog2(SUBDIV) : 1
) (
  input  logic             clk,
  input  logic             adv_i,
  input  crpi_pkg::coef_t  coef_i,
  input  logic [JW-1:0]    j_i,
  output crpi_pkg::coord_t sample_o
);

  localparam int CW    = crpi_pkg::COORD_W;
  localparam int AW    = crpi_pkg::ACC_W;
  // numerator denominator 2*S^3, rounding divisor 4*S^3 = 2^SH * ODD
  localparam int DEN   = 2 * SUBDIV * SUBDIV * SUBDIV;
  localparam int DV    = 2 * DEN;
  localparam int SH    = crpi_pkg::trail_zeros(DV);
  localparam int ODD   = DV >> SH;
  localparam int OB    = $clog2(ODD);
  localparam int NB    = CW + OB;
  localparam int KS    = NB + OB;
  localparam int MW    = KS + 1;
  localparam longint MULT = ((longint'(1) << KS) + longint'(ODD) - 1) / longint'(ODD);
  localparam longint LO   = -(longint'(1) << (CW - 1)) * longint'(DV);
  localparam longint HI   = ((longint'(1) << (CW - 1)) * longint'(DV)) - 1;
  localparam logic signed [AW-1:0] LO_A   = AW'(LO);
  localparam logic signed [AW-1:0] HI_A   = AW'(HI);
  localparam logic [MW-1:0]        MULT_C = MW'(MULT);
  localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  logic signed [AW-1:0] p1e, ae, be, ce;
  logic [7:0]           wa, wb, wc;
  logic signed [AW-1:0] t1_r, ta_r, tb_r, tc_r;
  logic signed [AW-1:0] sum_r, sum_nxt;
  logic signed [AW-1:0] off;
  logic [NB-1:0]        n_r;
  logic                 lo1_r, hi1_r, lo2_r, hi2_r;
  logic [NB+MW-1:0]     prod;
  logic [CW-1:0]        q_r;
  logic signed [CW-1:0] sample_r, sample_nxt;

  // stage 1: weighted terms
  always_comb begin
    p1e = AW'(coef_i.p1);
    ae  = AW'(coef_i.a);
    be  = AW'(coef_i.b);
    ce  = AW'(coef_i.c);
    wa  = crpi_pkg::w_lin(int'(j_i), SUBDIV);
    wb  = crpi_pkg::w_quad(int'(j_i), SUBDIV);
    wc  = crpi_pkg::w_cube(int'(j_i));
  end

  // stage 2: numerator with rounding bias, 2*num + den
  assign sum_nxt = AW'(2 * (t1_r + ta_r + tb_r + tc_r) + DEN);

  // stage 3: offset into the unsigned range and drop the power of two
  assign off = sum_r - LO_A;

  // stage 4: divide by the odd factor through an exact reciprocal
  assign prod = NB'(n_r) * MULT_C;

  // stage 5: saturate, remove the offset
  always_comb begin
    if (hi2_r) begin
      sample_nxt = SAT_MAX;
    end else if (lo2_r) begin
      sample_nxt = SAT_MIN;
    end else begin
      sample_nxt = {~q_r[CW-1], q_r[CW-2:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      t1_r     <= AW'(p1e * DEN);
      ta_r     <= AW'(ae * $signed({1'b0, wa}));
      tb_r     <= AW'(be * $signed({1'b0, wb}));
      tc_r     <= AW'(ce * $signed({1'b0, wc}));
      sum_r    <= sum_nxt;
      lo1_r    <= (sum_r < LO_A);
      hi1_r    <= (sum_r > HI_A);
      n_r      <= off[SH +: NB];
      lo2_r    <= lo1_r;
      hi2_r    <= hi1_r;
      q_r      <= prod[KS +: CW];
      sample_r <= sample_nxt;
    end
  end

  assign sample_o = sample_r;

endmodule

/* rtl/catmull_rom_polyline_interpolator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_polyline_interpolator: uniform Catmull-Rom polyline sampler
// Takes polyline points, emits SUBDIVISIONS samples per segment and the
// final point flagged as the end of the curve.
//
//   channel  dir  payload                               transfer
//   in_ch    in   point_x, point_y, final_point         valid && ready
//   out_ch   out  sample_x, sample_y, end_of_curve      valid && ready
//
// One sample leaves per cycle while out_ch.ready holds; the slot sequencer
// issues it. A point holds the input while the samples it releases issue:
// SUBDIVISIONS for a mid-line point, up to 2*SUBDIVISIONS+1 for a final
// point, none for the first two points unless final. The next point
// transfers as the last sample issues; reset is synchronous.
// A sample waiting on a low out_ch.ready freezes the whole sample pipeline.
// ----------------------------------------------------------------------------
module catmull_rom_polyline_interpolator #(
  parameter int SUBDIVISIONS = crpi_pkg::SUBDIV_DEF,
  localparam int JW          = (SUBDIVISIONS > 1) ? $clog2(SUBDIVISIONS) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  crpi_point_if.sink     in_ch,
  crpi_sample_if.source  out_ch
);

  localparam int DEPTH = crpi_pkg::PIPE_DEPTH;

  logic                   adv;
  logic                   issue;
  logic                   issue_end;
  logic [JW-1:0]          issue_j;
  crpi_pkg::coef_t        issue_cx;
  crpi_pkg::coef_t        issue_cy;
  crpi_pkg::seq_status_t  st;
  logic [DEPTH-1:0]       vld_r;
  logic [DEPTH-1:0]       eoc_r;

  // pipeline moves unless a result waits on a stalled sink
  assign adv = !vld_r[DEPTH-1] || out_ch.ready;

  crpi_seq #(.SUBDIV(SUBDIVISIONS)) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .adv_i       (adv),
    .issue_o     (issue),
    .issue_end_o (issue_end),
    .issue_j_o   (issue_j),
    .issue_cx_o  (issue_cx),
    .issue_cy_o  (issue_cy),
    .status_o    (st)
  );

  crpi_eval #(.SUBDIV(SUBDIVISIONS)) u_eval_x (
    .clk      (clk),
    .adv_i    (adv),
    .coef_i   (issue_cx),
    .j_i      (issue_j),
    .sample_o (out_ch.sample_x)
  );

  crpi_eval #(.SUBDIV(SUBDIVISIONS)) u_eval_y (
    .clk      (clk),
    .adv_i    (adv),
    .coef_i   (issue_cy),
    .j_i      (issue_j),
    .sample_o (out_ch.sample_y)
  );

  // valid and end flag alongside the datapath stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      eoc_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], issue};
      eoc_r <= {eoc_r[DEPTH-2:0], issue_end};
    end
  end

  assign out_ch.valid        = vld_r[DEPTH-1];
  assign out_ch.end_of_curve = eoc_r[DEPTH-1];

  // checks
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !st.busy |-> in_ch.ready)
    else $error("sequencer idle but input not ready");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.final_point) |=> (st.seen == 2'd0))
    else $error("window not cleared after final point");

  a_busy_take: assert property (@(posedge clk) disable iff (!rst_n)
    (st.busy && in_ch.ready) |-> adv)
    else $error("new point taken while pending slots are stalled");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("sample pipeline moved while stalled");

endmodule
